>>> design/rrnh_pkg.sv
// ----------------------------------------------------------------------------
// rrnh_pkg
// Types, widths and codes shared by the ray/rectangle nearest-hit block.
// ----------------------------------------------------------------------------
package rrnh_pkg;

   localparam int COORD_W = 24;   // Q16.8 coordinate
   localparam int WIDE_W  = 26;   // edge sums and differences
   localparam int DIST_W  = 48;   // Q32.16 squared distance
   localparam int ACC_W   = 54;   // cross-product accumulators
   localparam int MUL_W   = 32;   // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int QBITS   = 30;   // fraction bits of the hit parameter t
   localparam int QCNT_W  = $clog2(QBITS + 1);

   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_RECT  = 1'b1;

   localparam logic [1:0] EDGE_TOP    = 2'd0;
   localparam logic [1:0] EDGE_BOTTOM = 2'd1;
   localparam logic [1:0] EDGE_LEFT   = 2'd2;
   localparam logic [1:0] EDGE_RIGHT  = 2'd3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   typedef struct packed {
      logic                      action;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [DIST_W-1:0]         dist_sq;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SETUP  = 8'b0000_0010,
      ST_CROSS  = 8'b0000_0100,
      ST_CHECK  = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_SCALE  = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [COORD_W-1:0] v);
      widen = {{(WIDE_W - COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic logic signed [MUL_W-1:0] to_mul(input logic signed [WIDE_W-1:0] v);
      to_mul = {{(MUL_W - WIDE_W){v[WIDE_W-1]}}, v};
   endfunction

endpackage

>>> design/rrnh_mul.sv
// ----------------------------------------------------------------------------
// rrnh_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rrnh_mul (
   input  logic                                clock,
   input  logic signed [rrnh_pkg::MUL_W-1:0]   op_a,
   input  logic signed [rrnh_pkg::MUL_W-1:0]   op_b,
   output logic signed [rrnh_pkg::PROD_W-1:0]  prod
);
   import rrnh_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

>>> design/rrnh_div.sv
// ----------------------------------------------------------------------------
// rrnh_div
// Restoring fraction divider: floor(num * 2^QBITS / den) for num < den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrnh_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rrnh_pkg::ACC_W-1:0]    num,
   input  logic [rrnh_pkg::ACC_W-1:0]    den,
   output logic                          done,
   output logic [rrnh_pkg::QBITS-1:0]    quot
);
   import rrnh_pkg::*;

   logic [ACC_W-1:0]  rem_ff,  rem_in;
   logic [ACC_W-1:0]  den_ff,  den_in;
   logic [QBITS-1:0]  quot_ff, quot_in;
   logic [QCNT_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ACC_W-1:0]  shifted;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[ACC_W-2:0], 1'b0};
      if (start) begin
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= den_ff) begin
            rem_in  = shifted - den_ff;
            quot_in = {quot_ff[QBITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[QBITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == QCNT_W'(QBITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> design/ray_rect_nearest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_rect_nearest_hit_top
// Nearest hit of a ray against a stream of axis-aligned rectangles.
// ----------------------------------------------------------------------------
// A begin word (action 0) loads the ray start and far end. A rectangle word
// (action 1) is tested edge by edge (top, bottom, left, right); each edge runs
// a setup state, cross products on the shared multiplier and a check state, and
// an edge that is hit adds the bit-serial divider (one quotient bit a cycle)
// plus scaling and update states. A rectangle marked last adds a finish state.
// The time a rectangle takes is set by the single multiplier and the divider;
// req_stall stays high throughout. A rectangle marked last returns one rsp
// word, held in an output register while the next word is taken.
module ray_rect_nearest_hit_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rrnh_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrnh_pkg::rsp_type     rsp_data
);
   import rrnh_pkg::*;

   state_type state_ff, state_in;

   logic signed [COORD_W-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [COORD_W-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic                      hit_ff, hit_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;

   logic signed [WIDE_W-1:0]  lx_ff, lx_in, ty_ff, ty_in, rx_ff, rx_in, by_ff, by_in;
   logic                      last_ff, last_in;
   logic [1:0]                edge_ff, edge_in;
   logic [2:0]                cnt_ff, cnt_in;

   logic signed [WIDE_W-1:0]  rdx_ff, rdx_in, rdy_ff, rdy_in;
   logic signed [WIDE_W-1:0]  wdx_ff, wdx_in, wdy_ff, wdy_in;
   logic signed [WIDE_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [ACC_W-1:0]   den_ff, den_in, nt_ff, nt_in, nu_ff, nu_in;
   logic signed [WIDE_W-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic [PROD_W-1:0]         dsum_ff, dsum_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   prod_acc;
   logic                      div_start, div_done;
   logic [ACC_W-1:0]          div_num, div_den;
   logic [QBITS-1:0]          quot;

   logic signed [WIDE_W-1:0]  ea_x, ea_y, eb_x, eb_y;
   logic signed [ACC_W-1:0]   den_abs, nt_n, nu_n;
   logic signed [WIDE_W-1:0]  rdx_mag, rdy_mag, scaled;
   logic [PROD_W-1:0]         dsum_full;
   logic                      accept;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign prod_acc  = prod[ACC_W-1:0];
   assign rdx_mag   = rdx_ff[WIDE_W-1] ? -rdx_ff : rdx_ff;
   assign rdy_mag   = rdy_ff[WIDE_W-1] ? -rdy_ff : rdy_ff;
   assign scaled    = prod[QBITS+WIDE_W-1:QBITS];
   assign dsum_full = dsum_ff + prod;

   // edge endpoints
   always_comb begin
      case (edge_ff)
         EDGE_TOP: begin
            ea_x = lx_ff; ea_y = ty_ff; eb_x = rx_ff; eb_y = ty_ff;
         end
         EDGE_BOTTOM: begin
            ea_x = lx_ff; ea_y = by_ff; eb_x = rx_ff; eb_y = by_ff;
         end
         EDGE_LEFT: begin
            ea_x = lx_ff; ea_y = ty_ff; eb_x = lx_ff; eb_y = by_ff;
         end
         default: begin
            ea_x = rx_ff; ea_y = ty_ff; eb_x = rx_ff; eb_y = by_ff;
         end
      endcase
   end

   // sign-normalized cross products
   always_comb begin
      if (den_ff[ACC_W-1]) begin
         den_abs = -den_ff; nt_n = -nt_ff; nu_n = -nu_ff;
      end else begin
         den_abs = den_ff; nt_n = nt_ff; nu_n = nu_ff;
      end
   end

   // shared multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (state_ff == ST_CROSS) begin
         case (cnt_ff)
            3'd0:    begin op_a = to_mul(rdx_ff); op_b = to_mul(wdy_ff); end
            3'd1:    begin op_a = to_mul(rdy_ff); op_b = to_mul(wdx_ff); end
            3'd2:    begin op_a = to_mul(sx_ff);  op_b = to_mul(wdy_ff); end
            3'd3:    begin op_a = to_mul(sy_ff);  op_b = to_mul(wdx_ff); end
            3'd4:    begin op_a = to_mul(sx_ff);  op_b = to_mul(rdy_ff); end
            3'd5:    begin op_a = to_mul(sy_ff);  op_b = to_mul(rdx_ff); end
            default: begin op_a = '0;             op_b = '0;             end
         endcase
      end else if (state_ff == ST_SCALE) begin
         case (cnt_ff)
            3'd0:    begin op_a = to_mul(rdx_mag); op_b = MUL_W'(quot); end
            3'd1:    begin op_a = to_mul(rdy_mag); op_b = MUL_W'(quot); end
            3'd2:    begin op_a = to_mul(ox_in);   op_b = to_mul(ox_in); end
            3'd3:    begin op_a = to_mul(oy_in);   op_b = to_mul(oy_in); end
            default: begin op_a = '0;              op_b = '0;            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      start_x_in  = start_x_ff; start_y_in = start_y_ff;
      end_x_in    = end_x_ff;   end_y_in   = end_y_ff;
      hit_in      = hit_ff;     dist_in    = dist_ff;
      lx_in = lx_ff; ty_in = ty_ff; rx_in = rx_ff; by_in = by_ff;
      last_in = last_ff; edge_in = edge_ff; cnt_in = cnt_ff;
      rdx_in = rdx_ff; rdy_in = rdy_ff; wdx_in = wdx_ff; wdy_in = wdy_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      den_in = den_ff; nt_in = nt_ff; nu_in = nu_ff;
      ox_in = ox_ff; oy_in = oy_ff; dsum_in = dsum_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      div_start = 1'b0;
      div_num = nt_n[ACC_W-1:0];
      div_den = den_abs[ACC_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACTION_BEGIN) begin
                  start_x_in = req_data.first_x;  start_y_in = req_data.first_y;
                  end_x_in   = req_data.second_x; end_y_in   = req_data.second_y;
                  hit_in     = 1'b0;
                  dist_in    = '0;
               end else begin
                  lx_in   = widen(req_data.first_x);
                  ty_in   = widen(req_data.first_y);
                  rx_in   = widen(req_data.first_x) + widen(req_data.second_x);
                  by_in   = widen(req_data.first_y) + widen(req_data.second_y);
                  last_in = req_data.is_last;
                  edge_in = EDGE_TOP;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            rdx_in = widen(end_x_ff) - widen(start_x_ff);
            rdy_in = widen(end_y_ff) - widen(start_y_ff);
            wdx_in = eb_x - ea_x;
            wdy_in = eb_y - ea_y;
            sx_in  = ea_x - widen(start_x_ff);
            sy_in  = ea_y - widen(start_y_ff);
            cnt_in = '0;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            // accumulate the registered product issued in the previous cycle
            case (cnt_ff)
               3'd1:    den_in = prod_acc;
               3'd2:    den_in = den_ff - prod_acc;
               3'd3:    nt_in  = prod_acc;
               3'd4:    nt_in  = nt_ff - prod_acc;
               3'd5:    nu_in  = prod_acc;
               3'd6:    nu_in  = nu_ff - prod_acc;
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd6) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (den_ff == '0 || nt_n < 0 || nt_n >= den_abs || nu_n < 0 || nu_n > den_abs)
            begin
               edge_in = edge_ff + 1'b1;
               if (edge_ff == EDGE_RIGHT) state_in = last_ff ? ST_FINISH : ST_IDLE;
               else state_in = ST_SETUP;
            end else begin
               div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = '0;
            if (div_done) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            case (cnt_ff)
               3'd1: ox_in = rdx_ff[WIDE_W-1] ? -scaled : scaled;
               3'd2: oy_in = rdy_ff[WIDE_W-1] ? -scaled : scaled;
               3'd3: dsum_in = prod;
               default: ;
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 3'd3) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            end_x_in = start_x_ff + ox_ff[COORD_W-1:0];
            end_y_in = start_y_ff + oy_ff[COORD_W-1:0];
            hit_in   = 1'b1;
            dist_in  = (dsum_full > PROD_W'(DIST_MAX)) ? DIST_MAX : dsum_full[DIST_W-1:0];
            edge_in  = edge_ff + 1'b1;
            if (edge_ff == EDGE_RIGHT) state_in = last_ff ? ST_FINISH : ST_IDLE;
            else state_in = ST_SETUP;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.hit     = hit_ff;
               rsp_in.end_x   = end_x_ff;
               rsp_in.end_y   = end_y_ff;
               rsp_in.dist_sq = hit_ff ? dist_ff : '0;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_x_ff   <= '0; start_y_ff <= '0;
         end_x_ff     <= '0; end_y_ff   <= '0;
         hit_ff       <= 1'b0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         edge_ff      <= EDGE_TOP;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         start_x_ff   <= start_x_in; start_y_ff <= start_y_in;
         end_x_ff     <= end_x_in;   end_y_ff   <= end_y_in;
         hit_ff       <= hit_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
         edge_ff      <= edge_in;
         cnt_ff       <= cnt_in;
      end
      lx_ff <= lx_in; ty_ff <= ty_in; rx_ff <= rx_in; by_ff <= by_in;
      last_ff <= last_in;
      rdx_ff <= rdx_in; rdy_ff <= rdy_in; wdx_ff <= wdx_in; wdy_ff <= wdy_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      den_ff <= den_in; nt_ff <= nt_in; nu_ff <= nu_in;
      ox_ff <= ox_in; oy_ff <= oy_in; dsum_ff <= dsum_in;
      rsp_ff <= rsp_in;
   end

   rrnh_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   rrnh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside of the divide state");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside of the finish state");

   a_no_hit_no_dist: assert property (@(posedge clock) disable iff (reset)
      !hit_ff |-> dist_ff == '0)
      else $error("distance held without a hit");

   a_div_start_from_check: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIV)
      else $error("divider started without entering the divide state");

endmodule
